>>> sv/adsb_vfp_pkg.sv
// Shared types, constants and payload layout tables for the ADS-B vehicle frame parser.
// Used by adsb_vfp_core, adsb_vehicle_frame_parser and the testbench; depends on nothing else.
package adsb_vfp_pkg;

    localparam logic [7:0] START_BYTE        = 8'hFE;
    localparam logic [7:0] RESET_MSG_ID      = 8'd246;
    localparam logic [7:0] RESET_PAYLOAD_LEN = 8'd38;
    localparam logic [5:0] PAYLOAD_BYTES     = 6'd38;
    localparam logic [5:0] HDR_CHECK_POS     = 6'd4;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MSG_ID      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LEN = 8'd1;

    localparam logic [3:0] FID_ICAO     = 4'd0;
    localparam logic [3:0] FID_LAT      = 4'd1;
    localparam logic [3:0] FID_LON      = 4'd2;
    localparam logic [3:0] FID_ALT      = 4'd3;
    localparam logic [3:0] FID_HEADING  = 4'd4;
    localparam logic [3:0] FID_HVEL     = 4'd5;
    localparam logic [3:0] FID_VVEL     = 4'd6;
    localparam logic [3:0] FID_FLAGS    = 4'd7;
    localparam logic [3:0] FID_SQUAWK   = 4'd8;
    localparam logic [3:0] FID_ALT_TYPE = 4'd9;
    localparam logic [3:0] FID_CALLSIGN = 4'd10;
    localparam logic [3:0] FID_CALL_END = 4'd11;
    localparam logic [3:0] FID_EMITTER  = 4'd12;
    localparam logic [3:0] FID_TSLC     = 4'd13;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  field_id;
        logic [63:0] field_value;
        logic [7:0]  frame_sequence;
        logic [7:0]  system_id;
        logic [7:0]  component_id;
        logic        last_field;
    } result_t;

    // Field that owns a given payload byte position.
    function automatic logic [3:0] field_owner(input logic [5:0] pos);
        logic [3:0] id;
        case (pos)
            6'd0, 6'd1, 6'd2, 6'd3:     id = FID_ICAO;
            6'd4, 6'd5, 6'd6, 6'd7:     id = FID_LAT;
            6'd8, 6'd9, 6'd10, 6'd11:   id = FID_LON;
            6'd12, 6'd13, 6'd14, 6'd15: id = FID_ALT;
            6'd16, 6'd17:               id = FID_HEADING;
            6'd18, 6'd19:               id = FID_HVEL;
            6'd20, 6'd21:               id = FID_VVEL;
            6'd22, 6'd23:               id = FID_FLAGS;
            6'd24, 6'd25:               id = FID_SQUAWK;
            6'd26:                      id = FID_ALT_TYPE;
            6'd27, 6'd28, 6'd29, 6'd30,
            6'd31, 6'd32, 6'd33, 6'd34: id = FID_CALLSIGN;
            6'd35:                      id = FID_CALL_END;
            6'd36:                      id = FID_EMITTER;
            default:                    id = FID_TSLC;
        endcase
        return id;
    endfunction

    function automatic logic [5:0] field_first(input logic [3:0] id);
        logic [5:0] p;
        case (id)
            FID_ICAO:     p = 6'd0;
            FID_LAT:      p = 6'd4;
            FID_LON:      p = 6'd8;
            FID_ALT:      p = 6'd12;
            FID_HEADING:  p = 6'd16;
            FID_HVEL:     p = 6'd18;
            FID_VVEL:     p = 6'd20;
            FID_FLAGS:    p = 6'd22;
            FID_SQUAWK:   p = 6'd24;
            FID_ALT_TYPE: p = 6'd26;
            FID_CALLSIGN: p = 6'd27;
            FID_CALL_END: p = 6'd35;
            FID_EMITTER:  p = 6'd36;
            default:      p = 6'd37;
        endcase
        return p;
    endfunction

    function automatic logic [5:0] field_last(input logic [3:0] id);
        logic [5:0] p;
        case (id)
            FID_ICAO:     p = 6'd3;
            FID_LAT:      p = 6'd7;
            FID_LON:      p = 6'd11;
            FID_ALT:      p = 6'd15;
            FID_HEADING:  p = 6'd17;
            FID_HVEL:     p = 6'd19;
            FID_VVEL:     p = 6'd21;
            FID_FLAGS:    p = 6'd23;
            FID_SQUAWK:   p = 6'd25;
            FID_ALT_TYPE: p = 6'd26;
            FID_CALLSIGN: p = 6'd34;
            FID_CALL_END: p = 6'd35;
            FID_EMITTER:  p = 6'd36;
            default:      p = 6'd37;
        endcase
        return p;
    endfunction

endpackage

>>> sv/adsb_vfp_core.sv
// Frame state machine, header capture and field assembly for the ADS-B vehicle frame parser.
// Depends on adsb_vfp_pkg; state advances on each byte that step presents.
module adsb_vfp_core
    import adsb_vfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    exp_msg_id,
    input  logic [7:0]    exp_payload_len,
    output result_t       res
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [7:0]  hdr_len_reg, hdr_len_next;
    logic [7:0]  hdr_seq_reg, hdr_seq_next;
    logic [7:0]  hdr_sys_reg, hdr_sys_next;
    logic [7:0]  hdr_comp_reg, hdr_comp_next;
    logic [63:0] acc_reg, acc_next;

    logic        pos_ok;
    logic        hdr_match;
    logic [3:0]  owner;
    logic [5:0]  offset;
    logic        at_last;
    logic [63:0] acc_upd;

    assign pos_ok    = pos_reg < PAYLOAD_BYTES;
    assign hdr_match = (hdr_len_reg == exp_payload_len) && (rx_byte == exp_msg_id);
    assign owner     = field_owner(pos_reg);
    assign offset    = pos_reg - field_first(owner);
    assign at_last   = pos_ok && (pos_reg == field_last(owner));
    // ICAO address arrives big-endian; everything else lands little-endian.
    assign acc_upd   = (owner == FID_ICAO) ? {acc_reg[55:0], rx_byte}
                     : acc_reg | ({56'd0, rx_byte} << {offset[2:0], 3'b000});

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg >= HDR_CHECK_POS)
                begin
                    phase_next = hdr_match ? PH_PAYLOAD : PH_HUNT;
                    pos_next   = 6'd0;
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
            PH_PAYLOAD:
            begin
                if (!pos_ok || (at_last && owner == FID_TSLC))
                begin
                    phase_next = PH_HUNT;
                    pos_next   = 6'd0;
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_HEADER;
                    pos_next   = 6'd0;
                end
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        hdr_len_next  = hdr_len_reg;
        hdr_seq_next  = hdr_seq_reg;
        hdr_sys_next  = hdr_sys_reg;
        hdr_comp_next = hdr_comp_reg;
        acc_next      = acc_reg;
        res.valid          = 1'b0;
        res.field_id       = owner;
        res.field_value    = acc_upd;
        res.frame_sequence = hdr_seq_reg;
        res.system_id      = hdr_sys_reg;
        res.component_id   = hdr_comp_reg;
        res.last_field     = (owner == FID_TSLC);
        case (phase_reg)
            PH_HEADER:
            begin
                case (pos_reg)
                    6'd0:    hdr_len_next  = rx_byte;
                    6'd1:    hdr_seq_next  = rx_byte;
                    6'd2:    hdr_sys_next  = rx_byte;
                    6'd3:    hdr_comp_next = rx_byte;
                    default:
                    begin
                        if (hdr_match)
                        begin
                            acc_next = 64'd0;
                        end
                    end
                endcase
            end
            PH_PAYLOAD:
            begin
                if (pos_ok)
                begin
                    res.valid = at_last;
                    acc_next  = at_last ? 64'd0 : acc_upd;
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            pos_reg      <= 6'd0;
            hdr_len_reg  <= 8'd0;
            hdr_seq_reg  <= 8'd0;
            hdr_sys_reg  <= 8'd0;
            hdr_comp_reg <= 8'd0;
            acc_reg      <= 64'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            hdr_len_reg  <= hdr_len_next;
            hdr_seq_reg  <= hdr_seq_next;
            hdr_sys_reg  <= hdr_sys_next;
            hdr_comp_reg <= hdr_comp_next;
            acc_reg      <= acc_next;
        end
    end

`ifndef SYNTH
    a_payload_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> pos_reg < PAYLOAD_BYTES)
        else $error("payload position ran past the payload");

    a_header_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> pos_reg <= HDR_CHECK_POS)
        else $error("header position ran past the message id byte");

    a_tslc_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.last_field |=> phase_reg == PH_HUNT)
        else $error("parser did not return to hunting after the last field");
`endif

endmodule

>>> sv/adsb_vehicle_frame_parser.sv
// Top level of the ADS-B vehicle frame parser: input byte register, config registers,
// result register. Depends on adsb_vfp_pkg and adsb_vfp_core.
//
// Usage:
//   Bytes of the receiver stream enter on in_valid/in_ready/rx_byte, one per request.
//   Each payload field leaves on out_valid/out_ready with field_id, field_value, the
//   frame's sequence, system and component bytes, and last_field on the tslc field.
//   Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and cfg_data:
//   index 0 sets the expected message id, index 1 the expected length byte; other
//   indexes are dropped. cfg_ready is always high.
// Timing:
//   A byte is registered on acceptance and parsed from the input register; a field that
//   it completes is registered in the result register and then valid at the outputs.
//   One byte is taken every cycle unless a completed field is blocked (see Stall);
//   the rate is set by the single pass through the parser core per byte.
// Reset:
//   rst_n clears the parser to hunting for the start byte, empties both registers and
//   restores the expected message id to 246 and the expected length to 38.
// Stall:
//   While a result waits on out_ready, a byte that yields no result still advances;
//   a byte that completes a field holds in the input register, and a further byte
//   is refused until the result is taken.
module adsb_vehicle_frame_parser
    import adsb_vfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             field_id,
    output logic [63:0]            field_value,
    output logic [7:0]             frame_sequence,
    output logic [7:0]             system_id,
    output logic [7:0]             component_id,
    output logic                   last_field,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  msg_id_reg;
    logic [7:0]  payload_len_reg;
    result_t     res;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        slot_free;
    logic        advance;

    assign slot_free = !out_valid_reg || out_ready;
    // A byte that yields nothing may pass even while the result register is full.
    assign advance   = byte_valid_reg && (slot_free || !res.valid);
    assign in_ready  = !byte_valid_reg || advance;
    assign cfg_ready = 1'b1;

    adsb_vfp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .rx_byte         (byte_reg),
        .exp_msg_id      (msg_id_reg),
        .exp_payload_len (payload_len_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_id_reg      <= RESET_MSG_ID;
            payload_len_reg <= RESET_PAYLOAD_LEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MSG_ID:      msg_id_reg      <= cfg_data;
                REG_PAYLOAD_LEN: payload_len_reg <= cfg_data;
                default:         msg_id_reg      <= msg_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign field_id       = out_reg.field_id;
    assign field_value    = out_reg.field_value;
    assign frame_sequence = out_reg.frame_sequence;
    assign system_id      = out_reg.system_id;
    assign component_id   = out_reg.component_id;
    assign last_field     = out_reg.last_field;

`ifndef SYNTH
    a_last_is_tslc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_field |-> field_id == FID_TSLC)
        else $error("last_field raised on a field other than tslc");

    a_refuse_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> byte_valid_reg && res.valid && out_valid_reg && !out_ready)
        else $error("input refused without a blocked result");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid |=> out_valid)
        else $error("parsed field was not presented at the outputs");
`endif

endmodule

>>> tb/sv/tb_adsb_vehicle_frame_parser.sv
`timescale 1ns / 1ps
// Testbench for adsb_vehicle_frame_parser: feeds byte streams of good, broken and noise
// frames, predicts every payload field and checks it on the result port.
// Depends on adsb_vfp_pkg and the parser RTL.

import adsb_vfp_pkg::*;

typedef struct packed {
    logic [3:0]  id;
    logic [63:0] value;
    logic [7:0]  seq;
    logic [7:0]  sys;
    logic [7:0]  comp;
    logic        last;
} field_rec_t;

class field_scoreboard;
    logic [7:0]  msg_id_reg;
    logic [7:0]  len_reg;
    phase_t      phase;
    logic [5:0]  pos;
    logic [7:0]  hdr_len;
    logic [7:0]  hdr_seq;
    logic [7:0]  hdr_sys;
    logic [7:0]  hdr_comp;
    logic [63:0] acc;
    logic [5:0]  field_end [14];
    field_rec_t  pending [$];
    int          fail_count;

    function new();
        field_end = '{6'd3, 6'd7, 6'd11, 6'd15, 6'd17, 6'd19, 6'd21, 6'd23, 6'd25, 6'd26,
                      6'd34, 6'd35, 6'd36, 6'd37};
        msg_id_reg = RESET_MSG_ID;
        len_reg    = RESET_PAYLOAD_LEN;
        phase      = PH_HUNT;
        pos        = '0;
        hdr_len    = '0;
        hdr_seq    = '0;
        hdr_sys    = '0;
        hdr_comp   = '0;
        acc        = '0;
        fail_count = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
        if (idx == REG_MSG_ID)
            msg_id_reg = data;
        else if (idx == REG_PAYLOAD_LEN)
            len_reg = data;
    endfunction

    function logic [3:0] owner_of(logic [5:0] p);
        logic [3:0] id;
        id = FID_TSLC;
        for (int i = 13; i >= 0; i--)
            if (field_end[i] >= p)
                id = 4'(i);
        return id;
    endfunction

    // Advance the parser copy by one accepted byte; queue the field it completes.
    function void note_byte(logic [7:0] b);
        logic [3:0] id;
        logic [5:0] first;
        logic [2:0] k;
        field_rec_t rec;
        case (phase)
            PH_HEADER:
            begin
                case (pos)
                    6'd0: hdr_len  = b;
                    6'd1: hdr_seq  = b;
                    6'd2: hdr_sys  = b;
                    6'd3: hdr_comp = b;
                    default:
                    begin
                        if (hdr_len == len_reg && b == msg_id_reg)
                            phase = PH_PAYLOAD;
                        else
                            phase = PH_HUNT;
                        acc = '0;
                    end
                endcase
                if (pos >= HDR_CHECK_POS)
                    pos = '0;
                else
                    pos = pos + 6'd1;
            end
            PH_PAYLOAD:
            begin
                if (pos >= PAYLOAD_BYTES)
                begin
                    phase = PH_HUNT;
                    pos   = '0;
                end
                else
                begin
                    id    = owner_of(pos);
                    first = (id == FID_ICAO) ? 6'd0 : field_end[id - 4'd1] + 6'd1;
                    k     = 3'(pos - first);
                    // ICAO arrives most significant byte first, the rest least first
                    if (id == FID_ICAO)
                        acc = {acc[55:0], b};
                    else
                        acc = acc | (64'(b) << (8 * k));
                    if (pos == field_end[id])
                    begin
                        rec.id    = id;
                        rec.value = acc;
                        rec.seq   = hdr_seq;
                        rec.sys   = hdr_sys;
                        rec.comp  = hdr_comp;
                        rec.last  = (id == FID_TSLC);
                        pending.push_back(rec);
                        acc = '0;
                    end
                    if (pos == field_end[id] && id == FID_TSLC)
                    begin
                        phase = PH_HUNT;
                        pos   = '0;
                    end
                    else
                        pos = pos + 6'd1;
                end
            end
            default:
            begin
                if (b == START_BYTE)
                begin
                    phase = PH_HEADER;
                    pos   = '0;
                end
                else
                    phase = PH_HUNT;
            end
        endcase
    endfunction

    function void report_fail(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(field_rec_t got);
        field_rec_t want;
        if (pending.size() == 0)
        begin
            report_fail($sformatf("unexpected field: id=%0d value=%h", got.id, got.value));
            return;
        end
        want = pending.pop_front();
        if (got.id !== want.id || got.value !== want.value || got.seq !== want.seq
            || got.sys !== want.sys || got.comp !== want.comp || got.last !== want.last)
            report_fail($sformatf({"field mismatch: expected id=%0d value=%h seq=%h sys=%h ",
                "comp=%h last=%b, got id=%0d value=%h seq=%h sys=%h comp=%h last=%b"},
                want.id, want.value, want.seq, want.sys, want.comp, want.last,
                got.id, got.value, got.seq, got.sys, got.comp, got.last));
    endfunction
endclass

module tb_adsb_vehicle_frame_parser;

    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_BYTES  = 1100;
    localparam int REG_COUNT     = 2;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EDGES} fill_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [3:0]             field_id;
    logic [63:0]            field_value;
    logic [7:0]             frame_sequence;
    logic [7:0]             system_id;
    logic [7:0]             component_id;
    logic                   last_field;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    field_scoreboard sb;
    idle_t           in_idle  = IDLE_NONE;
    idle_t           out_idle = IDLE_NONE;
    bit              hold_request = 1'b0;
    int              bytes_sent = 0;
    int              cycle_count = 0;

    adsb_vehicle_frame_parser i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .field_id       (field_id),
        .field_value    (field_value),
        .frame_sequence (frame_sequence),
        .system_id      (system_id),
        .component_id   (component_id),
        .last_field     (last_field),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap(idle_t mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            default:    return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    function automatic logic [7:0] pick_byte(fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_EDGES:
            begin
                case ($urandom_range(0, 3))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    2:       return START_BYTE;
                    default: return 8'($urandom);
                endcase
            end
            default:   return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_reg(logic [7:0] dflt);
        case ($urandom_range(0, 4))
            0, 1:    return dflt;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic release_input();
        in_valid = 1'b0;
        rx_byte  = 8'($urandom);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance, valid held.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(in_idle);
        if (gap > 0)
        begin
            release_input();
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_header(input logic [7:0] len_b, input logic [7:0] id_b,
                               input bit with_start, input fill_t fill);
        if (with_start)
            send_byte(START_BYTE);
        send_byte(len_b);
        send_byte(pick_byte(fill));
        send_byte(pick_byte(fill));
        send_byte(pick_byte(fill));
        send_byte(id_b);
    endtask

    task automatic send_payload(input fill_t fill, input int count);
        repeat (count) send_byte(pick_byte(fill));
    endtask

    task automatic send_crc();
        send_byte(8'($urandom));
        send_byte(8'($urandom));
    endtask

    task automatic send_frame(input fill_t fill);
        send_header(sb.len_reg, sb.msg_id_reg, 1'b1, fill);
        send_payload(fill, PAYLOAD_BYTES);
        send_crc();
    endtask

    // Stop offering bytes until every predicted field is out and the pipe is empty.
    task automatic wait_idle();
        release_input();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic reconfigure(input logic [7:0] id_v, input logic [7:0] len_v);
        wait_idle();
        write_reg(REG_MSG_ID, id_v);
        write_reg(REG_PAYLOAD_LEN, len_v);
        cfg_valid = 1'b0;
    endtask

    // Result side: random stalls, one long hold on request.
    initial
    begin
        field_rec_t got;
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = draw_gap(out_idle);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.id    = field_id;
            got.value = field_value;
            got.seq   = frame_sequence;
            got.sys   = system_id;
            got.comp  = component_id;
            got.last  = last_field;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] v_id;
        logic [7:0] v_len;
        int         choice;
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset register values, all-zero and all-one frames
        send_frame(FILL_ZERO);
        send_frame(FILL_ONES);
        reconfigure(RESET_MSG_ID, RESET_PAYLOAD_LEN);
        in_idle  = IDLE_FULL;
        out_idle = IDLE_FULL;
        send_frame(FILL_EDGES);

        // drop on wrong length, then on wrong id; zero filler stays in the hunt
        send_header(sb.len_reg + 8'd1, sb.msg_id_reg, 1'b1, FILL_RANDOM);
        send_payload(FILL_ZERO, 6);
        send_header(sb.len_reg, ~sb.msg_id_reg, 1'b1, FILL_RANDOM);
        send_payload(FILL_ZERO, 6);

        // a start byte in the checksum opens the next header
        send_header(sb.len_reg, sb.msg_id_reg, 1'b1, FILL_EDGES);
        send_payload(FILL_EDGES, PAYLOAD_BYTES);
        send_byte(START_BYTE);
        send_header(sb.len_reg, sb.msg_id_reg, 1'b0, FILL_RANDOM);
        send_payload(FILL_RANDOM, PAYLOAD_BYTES);
        send_crc();

        // length register changed mid-header applies at the header check
        send_byte(START_BYTE);
        send_byte(8'd10);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        wait_idle();
        write_reg(REG_PAYLOAD_LEN, 8'd10);
        cfg_valid = 1'b0;
        send_byte(8'($urandom));
        send_byte(sb.msg_id_reg);
        send_payload(FILL_RANDOM, PAYLOAD_BYTES);
        send_crc();

        // register extremes, with 38 payload bytes whatever the length byte says
        reconfigure(8'h00, 8'h00);
        send_frame(FILL_RANDOM);
        reconfigure(8'hFF, 8'hFF);
        send_frame(FILL_EDGES);

        // writes to unknown indexes must leave both registers alone
        wait_idle();
        write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, 254)), 8'($urandom));
        write_reg('1, 8'($urandom));
        cfg_valid = 1'b0;
        send_frame(FILL_RANDOM);
        reconfigure(RESET_MSG_ID, RESET_PAYLOAD_LEN);

        // hold the result side while bytes keep coming, then pause until drained
        in_idle      = IDLE_NONE;
        out_idle     = IDLE_NONE;
        hold_request = 1'b1;
        repeat (3) send_frame(FILL_RANDOM);
        wait_idle();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            v_id     = pick_reg(RESET_MSG_ID);
            v_len    = pick_reg(RESET_PAYLOAD_LEN);
            reconfigure(v_id, v_len);
            in_idle  = idle_t'($urandom_range(0, 2));
            out_idle = idle_t'($urandom_range(0, 2));
            repeat ($urandom_range(3, 8))
            begin
                choice = $urandom_range(0, 9);
                if (choice < 5)
                    send_frame(FILL_RANDOM);
                else if (choice == 5)
                    send_frame(FILL_EDGES);
                else if (choice == 6)
                    send_frame(fill_t'($urandom_range(0, 3)));
                else if (choice == 7)
                begin
                    // broken header: length or id off by one bit
                    if ($urandom_range(0, 1) == 0)
                        send_header(sb.len_reg ^ (8'd1 << $urandom_range(0, 7)),
                                    sb.msg_id_reg, 1'b1, FILL_RANDOM);
                    else
                        send_header(sb.len_reg, sb.msg_id_reg ^ (8'd1 << $urandom_range(0, 7)),
                                    1'b1, FILL_RANDOM);
                    send_payload(FILL_RANDOM, $urandom_range(0, 40));
                end
                else if (choice == 8)
                begin
                    // truncated frame: what follows is taken as payload
                    send_header(sb.len_reg, sb.msg_id_reg, 1'b1, FILL_RANDOM);
                    send_payload(FILL_RANDOM, $urandom_range(1, 37));
                end
                else
                    repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
            end
        end

        wait_idle();
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> adsb_vehicle_frame_parser.f
sv/adsb_vfp_pkg.sv
sv/adsb_vfp_core.sv
sv/adsb_vehicle_frame_parser.sv
tb/sv/tb_adsb_vehicle_frame_parser.sv
